>>> src/quad_size_check_macros.svh
// Assertion macros for the quad size check block.
`ifndef QUAD_SIZE_CHECK_MACROS_SVH
`define QUAD_SIZE_CHECK_MACROS_SVH
`ifndef ASSERT_OFF
`define QSC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define QSC_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define QSC_ASSERT(lbl, prop, msg)
`define QSC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> src/qsc_pkg.sv
`default_nettype none
package qsc_pkg;

   localparam int CsrAddrWidth = 4;
   localparam int CsrDataWidth = 32;

   localparam logic [1:0] REG_LENGTH_TOL = 2'd0;
   localparam logic [1:0] REG_AREA_TOL   = 2'd1;
   localparam logic [1:0] REG_AREA_EN    = 2'd2;

   localparam logic [15:0] LENGTH_TOL_RESET = 16'd160;
   localparam logic [23:0] AREA_TOL_RESET   = 24'd1000;
   localparam logic        AREA_EN_RESET    = 1'b1;

   typedef struct packed {
      logic [15:0] length_tolerance;
      logic [23:0] area_tolerance;
      logic        area_check_enable;
   } cfg_type;

   typedef struct packed {
      logic        passed;
      logic        length_ok;
      logic [31:0] quad_area;
   } result_type;

endpackage
`default_nettype wire

>>> src/qsc_csr.sv
`default_nettype none
module qsc_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [qsc_pkg::CsrAddrWidth-1:0]    paddr,
   input  wire logic [qsc_pkg::CsrDataWidth-1:0]    pwdata,
   output logic      [qsc_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                     pready,
   output qsc_pkg::cfg_type                         cfg
);
   import qsc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[3:2])
            REG_LENGTH_TOL: cfg_in.length_tolerance  = pwdata[15:0];
            REG_AREA_TOL:   cfg_in.area_tolerance    = pwdata[23:0];
            REG_AREA_EN:    cfg_in.area_check_enable = pwdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_LENGTH_TOL: prdata = {16'd0, cfg_ff.length_tolerance};
         REG_AREA_TOL:   prdata = {8'd0, cfg_ff.area_tolerance};
         REG_AREA_EN:    prdata = {31'd0, cfg_ff.area_check_enable};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.length_tolerance  <= LENGTH_TOL_RESET;
         cfg_ff.area_tolerance    <= AREA_TOL_RESET;
         cfg_ff.area_check_enable <= AREA_EN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

>>> src/qsc_eval.sv
`default_nettype none
module qsc_eval #(
   parameter int COORD_WIDTH     = 16,
   parameter int COORD_FRAC_BITS = 4
) (
   input  wire logic [COORD_WIDTH-1:0] x [4],
   input  wire logic [COORD_WIDTH-1:0] y [4],
   input  wire logic [11:0]            target_len_x,
   input  wire logic [11:0]            target_len_y,
   input  wire logic [23:0]            target_area,
   input  qsc_pkg::cfg_type            cfg,
   output qsc_pkg::result_type         res
);
   import qsc_pkg::*;

   localparam int W    = COORD_WIDTH;
   localparam int F    = COORD_FRAC_BITS;
   localparam int LW0  = (W + 2 > 13 + F) ? W + 2 : 13 + F;
   localparam int LW   = ((LW0 > 17) ? LW0 : 17) + 1;
   localparam int MAGW = 2 * W + 3;
   localparam int AW   = ((MAGW > 25 + 2 * F) ? MAGW : 25 + 2 * F) + 1;
   localparam int SCW  = (MAGW + 7 > 33) ? MAGW + 7 : 33;
   localparam int SHL  = (2 * F <= 7) ? 7 - 2 * F : 0;
   localparam int SHR  = (2 * F > 7) ? 2 * F - 7 : 0;

   logic signed [W:0] sx [4];
   logic signed [W:0] sy [4];
   logic signed [W:0] dx10, dx23, dy30, dy21;
   logic        [W:0] mx10, mx23, my30, my21;
   logic     [LW-1:0] lx, ly, tlx2, tly2, ltol2, dlx, dly;
   logic              len_ok;

   logic signed [W:0]       ax, by, bx, ay;
   logic signed [2*W+1:0]   prod_p, prod_q;
   logic signed [MAGW-1:0]  area2;
   logic        [MAGW-1:0]  area2_mag;
   logic        [SCW-1:0]   scaled;
   logic        [AW-1:0]    am, at2, atol2, dar;
   logic                    area_ok;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sx[i] = $signed({x[i][W-1], x[i]});
         sy[i] = $signed({y[i][W-1], y[i]});
      end
   end

   // side lengths at F fraction bits, compared doubled
   assign dx10 = sx[1] - sx[0];
   assign dx23 = sx[2] - sx[3];
   assign dy30 = sy[3] - sy[0];
   assign dy21 = sy[2] - sy[1];
   assign mx10 = dx10[W] ? unsigned'(-dx10) : unsigned'(dx10);
   assign mx23 = dx23[W] ? unsigned'(-dx23) : unsigned'(dx23);
   assign my30 = dy30[W] ? unsigned'(-dy30) : unsigned'(dy30);
   assign my21 = dy21[W] ? unsigned'(-dy21) : unsigned'(dy21);

   assign lx    = LW'(mx10) + LW'(mx23);
   assign ly    = LW'(my30) + LW'(my21);
   assign tlx2  = LW'(target_len_x) << (F + 1);
   assign tly2  = LW'(target_len_y) << (F + 1);
   assign ltol2 = LW'({cfg.length_tolerance, 1'b0});
   assign dlx   = (lx >= tlx2) ? lx - tlx2 : tlx2 - lx;
   assign dly   = (ly >= tly2) ? ly - tly2 : tly2 - ly;
   assign len_ok = (dlx <= ltol2) && (dly <= ltol2);

   // twice the shoelace area from the diagonals
   assign ax = sx[0] - sx[2];
   assign by = sy[1] - sy[3];
   assign bx = sx[1] - sx[3];
   assign ay = sy[0] - sy[2];
   assign prod_p = ax * by;
   assign prod_q = bx * ay;
   assign area2  = $signed({prod_p[2*W+1], prod_p}) - $signed({prod_q[2*W+1], prod_q});
   assign area2_mag = area2[MAGW-1] ? unsigned'(-area2) : unsigned'(area2);

   assign scaled = (SCW'(area2_mag) << SHL) >> SHR;

   assign am    = AW'(area2_mag);
   assign at2   = AW'(target_area) << (2 * F + 1);
   assign atol2 = AW'(cfg.area_tolerance) << (2 * F + 1);
   assign dar   = (am >= at2) ? am - at2 : at2 - am;
   assign area_ok = (dar <= atol2);

   always_comb begin
      res.length_ok = len_ok;
      res.passed    = len_ok && (!cfg.area_check_enable || area_ok);
      res.quad_area = (|scaled[SCW-1:32]) ? 32'hFFFF_FFFF : scaled[31:0];
   end

endmodule
`default_nettype wire

>>> src/quad_size_check.sv
// Channel | Ports                               | Direction | Handshake
// req     | req_corner*_x/_y, req_target_*      | in        | req_valid / req_stall
// rsp     | rsp_passed, rsp_length_ok, rsp_quad_area | out  | rsp_valid / rsp_stall
// csr     | psel penable pwrite paddr pwdata prdata pready | in/out | APB read/write
//
// One item per cycle unless req_stall holds off the request; each accepted item is
// captured in the input register, then its result in the result register.
// Reset clears both stage valids and loads the CSR registers with their defaults.
// req_stall rises only while the input stage is full and a held result is stalled.
`default_nettype none
`include "quad_size_check_macros.svh"
module quad_size_check #(
   parameter int COORD_WIDTH     = 16,
   parameter int COORD_FRAC_BITS = 4
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [COORD_WIDTH-1:0]           req_corner0_x,
   input  wire logic [COORD_WIDTH-1:0]           req_corner0_y,
   input  wire logic [COORD_WIDTH-1:0]           req_corner1_x,
   input  wire logic [COORD_WIDTH-1:0]           req_corner1_y,
   input  wire logic [COORD_WIDTH-1:0]           req_corner2_x,
   input  wire logic [COORD_WIDTH-1:0]           req_corner2_y,
   input  wire logic [COORD_WIDTH-1:0]           req_corner3_x,
   input  wire logic [COORD_WIDTH-1:0]           req_corner3_y,
   input  wire logic [11:0]                      req_target_len_x,
   input  wire logic [11:0]                      req_target_len_y,
   input  wire logic [23:0]                      req_target_area,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_passed,
   output logic                                  rsp_length_ok,
   output logic [31:0]                           rsp_quad_area,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [qsc_pkg::CsrAddrWidth-1:0] paddr,
   input  wire logic [qsc_pkg::CsrDataWidth-1:0] pwdata,
   output logic      [qsc_pkg::CsrDataWidth-1:0] prdata,
   output logic                                  pready
);
   import qsc_pkg::*;

   cfg_type    cfg;
   result_type eval_res;

   logic                   s1_valid_ff, s1_valid_in;
   logic [COORD_WIDTH-1:0] x_ff [4];
   logic [COORD_WIDTH-1:0] y_ff [4];
   logic [COORD_WIDTH-1:0] x_in [4];
   logic [COORD_WIDTH-1:0] y_in [4];
   logic [11:0]            tlx_ff, tlx_in, tly_ff, tly_in;
   logic [23:0]            tarea_ff, tarea_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             res_ff, res_in;
   logic                   out_free, load_s1;

   qsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   qsc_eval #(
      .COORD_WIDTH     (COORD_WIDTH),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_eval (
      .x            (x_ff),
      .y            (y_ff),
      .target_len_x (tlx_ff),
      .target_len_y (tly_ff),
      .target_area  (tarea_ff),
      .cfg          (cfg),
      .res          (eval_res)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_free;
   assign load_s1   = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = load_s1 || (s1_valid_ff && !out_free);
      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
      res_in       = (out_free && s1_valid_ff) ? eval_res : res_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      tlx_in   = tlx_ff;
      tly_in   = tly_ff;
      tarea_in = tarea_ff;
      if (load_s1) begin
         x_in[0]  = req_corner0_x;
         y_in[0]  = req_corner0_y;
         x_in[1]  = req_corner1_x;
         y_in[1]  = req_corner1_y;
         x_in[2]  = req_corner2_x;
         y_in[2]  = req_corner2_y;
         x_in[3]  = req_corner3_x;
         y_in[3]  = req_corner3_y;
         tlx_in   = req_target_len_x;
         tly_in   = req_target_len_y;
         tarea_in = req_target_area;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      tlx_ff   <= tlx_in;
      tly_ff   <= tly_in;
      tarea_ff <= tarea_in;
      res_ff   <= res_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_passed    = res_ff.passed;
   assign rsp_length_ok = res_ff.length_ok;
   assign rsp_quad_area = res_ff.quad_area;

   `QSC_ASSERT(a_pass_needs_len, rsp_valid |-> (!rsp_passed || rsp_length_ok), "pass without length")
   `QSC_ASSERT(a_stall_only_full, req_stall |-> s1_valid_ff, "stall with empty input stage")
   `QSC_ASSERT(a_item_moves, (s1_valid_ff && out_free) |=> rsp_valid, "item lost between stages")
   `QSC_ASSERT_RST(a_reset_clears, reset |=> (!rsp_valid && !req_stall), "not idle after reset")

endmodule
`default_nettype wire

>>> tb/quad_size_check_checker.sv
module quad_size_check_checker #(
   parameter int COORD_WIDTH     = 16,
   parameter int COORD_FRAC_BITS = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [COORD_WIDTH-1:0]           req_corner0_x,
   input  logic [COORD_WIDTH-1:0]           req_corner0_y,
   input  logic [COORD_WIDTH-1:0]           req_corner1_x,
   input  logic [COORD_WIDTH-1:0]           req_corner1_y,
   input  logic [COORD_WIDTH-1:0]           req_corner2_x,
   input  logic [COORD_WIDTH-1:0]           req_corner2_y,
   input  logic [COORD_WIDTH-1:0]           req_corner3_x,
   input  logic [COORD_WIDTH-1:0]           req_corner3_y,
   input  logic [11:0]                      req_target_len_x,
   input  logic [11:0]                      req_target_len_y,
   input  logic [23:0]                      req_target_area,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic                             rsp_passed,
   input  logic                             rsp_length_ok,
   input  logic [31:0]                      rsp_quad_area,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic                             pready,
   input  logic [qsc_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [qsc_pkg::CsrDataWidth-1:0] pwdata,
   output int                               mismatches,
   output int                               outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import qsc_pkg::*;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   cfg_type    limits;
   result_type expected_results[$];
   int         bad_results = 0;

   function automatic logic [63:0] span(input coord_type a, input coord_type b);
      logic signed [COORD_WIDTH:0] d;
      d = a - b;
      return d < 0 ? 64'(-d) : 64'(d);
   endfunction

   function automatic bit near(input logic [63:0] a, input logic [63:0] b,
                               input logic [63:0] tol);
      return (a >= b ? a - b : b - a) <= tol;
   endfunction

   function automatic result_type size_check(
      input coord_type x0, input coord_type y0, input coord_type x1, input coord_type y1,
      input coord_type x2, input coord_type y2, input coord_type x3, input coord_type y3,
      input logic [11:0] tx, input logic [11:0] ty, input logic [23:0] ta,
      input cfg_type cfg);
      logic [63:0]                   lx, ly, twice_mag, scaled;
      logic signed [COORD_WIDTH:0]   ax, by, bx, ay;
      logic signed [2*COORD_WIDTH+2:0] twice_area;
      logic                          area_ok;
      result_type                    r;
      lx = span(x1, x0) + span(x2, x3);
      ly = span(y3, y0) + span(y2, y1);
      r.length_ok = near(lx, 64'(tx) << (COORD_FRAC_BITS + 1), 64'(cfg.length_tolerance) << 1)
                 && near(ly, 64'(ty) << (COORD_FRAC_BITS + 1), 64'(cfg.length_tolerance) << 1);
      // shoelace, doubled, at 2F fraction bits
      ax = x0 - x2;
      by = y1 - y3;
      bx = x1 - x3;
      ay = y0 - y2;
      twice_area = ax * by - bx * ay;
      twice_mag = twice_area < 0 ? 64'(-twice_area) : 64'(twice_area);
      if (2 * COORD_FRAC_BITS <= 7) begin
         scaled = twice_mag << (7 - 2 * COORD_FRAC_BITS);
      end else begin
         scaled = twice_mag >> (2 * COORD_FRAC_BITS - 7);
      end
      r.quad_area = scaled > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : scaled[31:0];
      area_ok = near(twice_mag, 64'(ta) << (2 * COORD_FRAC_BITS + 1),
                     64'(cfg.area_tolerance) << (2 * COORD_FRAC_BITS + 1));
      r.passed = r.length_ok && (!cfg.area_check_enable || area_ok);
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want;
      result_type fresh;
      if (reset) begin
         limits <= '{LENGTH_TOL_RESET, AREA_TOL_RESET, AREA_EN_RESET};
         expected_results.delete();
         bad_results = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               bad_results++;
               if (bad_results <= 10) begin
                  $display("%0t: unexpected item: passed %0b length_ok %0b quad_area %0d",
                           $realtime, rsp_passed, rsp_length_ok, rsp_quad_area);
               end
            end else begin
               want = expected_results.pop_front();
               if (rsp_passed !== want.passed || rsp_length_ok !== want.length_ok
                   || rsp_quad_area !== want.quad_area) begin
                  bad_results++;
                  if (bad_results <= 10) begin
                     $display("%0t: mismatch: passed %0b/%0b length_ok %0b/%0b quad_area %0d/%0d",
                              $realtime, want.passed, rsp_passed, want.length_ok,
                              rsp_length_ok, want.quad_area, rsp_quad_area);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            fresh = size_check(
               req_corner0_x, req_corner0_y, req_corner1_x, req_corner1_y,
               req_corner2_x, req_corner2_y, req_corner3_x, req_corner3_y,
               req_target_len_x, req_target_len_y, req_target_area, limits);
            expected_results.insert(expected_results.size(), fresh);
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[CsrAddrWidth-1:2])
               REG_LENGTH_TOL: limits.length_tolerance  <= pwdata[15:0];
               REG_AREA_TOL:   limits.area_tolerance    <= pwdata[23:0];
               REG_AREA_EN:    limits.area_check_enable <= pwdata[0];
               default: ;
            endcase
         end
      end
      mismatches  <= bad_results;
      outstanding <= expected_results.size();
   end

endmodule

>>> tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import qsc_pkg::*;

   typedef struct packed {
      logic [15:0] x0, y0, x1, y1, x2, y2, x3, y3;
      logic [11:0] len_x, len_y;
      logic [23:0] area;
   } quad_req_type;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   quad_req_type            req_item  = '0;
   logic                    req_stall;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_passed;
   logic                    rsp_length_ok;
   logic [31:0]             rsp_quad_area;
   logic                    psel      = 1'b0;
   logic                    penable   = 1'b0;
   logic                    pwrite    = 1'b0;
   logic [CsrAddrWidth-1:0] paddr     = '0;
   logic [CsrDataWidth-1:0] pwdata    = '0;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;
   int                      mismatches;
   int                      outstanding;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int hold_seen     = 0;
   int hold_left     = 0;

   quad_size_check u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_corner0_x    (req_item.x0),
      .req_corner0_y    (req_item.y0),
      .req_corner1_x    (req_item.x1),
      .req_corner1_y    (req_item.y1),
      .req_corner2_x    (req_item.x2),
      .req_corner2_y    (req_item.y2),
      .req_corner3_x    (req_item.x3),
      .req_corner3_y    (req_item.y3),
      .req_target_len_x (req_item.len_x),
      .req_target_len_y (req_item.len_y),
      .req_target_area  (req_item.area),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_passed       (rsp_passed),
      .rsp_length_ok    (rsp_length_ok),
      .rsp_quad_area    (rsp_quad_area),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   quad_size_check_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_corner0_x    (req_item.x0),
      .req_corner0_y    (req_item.y0),
      .req_corner1_x    (req_item.x1),
      .req_corner1_y    (req_item.y1),
      .req_corner2_x    (req_item.x2),
      .req_corner2_y    (req_item.y2),
      .req_corner3_x    (req_item.x3),
      .req_corner3_y    (req_item.y3),
      .req_target_len_x (req_item.len_x),
      .req_target_len_y (req_item.len_y),
      .req_target_area  (req_item.area),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_passed       (rsp_passed),
      .rsp_length_ok    (rsp_length_ok),
      .rsp_quad_area    (rsp_quad_area),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .pready           (pready),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= $urandom_range(99) < rsp_stall_pct;
         end
      end
   end

   function automatic logic [15:0] coord(input int v);
      return 16'(v < -32768 ? -32768 : (v > 32767 ? 32767 : v));
   endfunction

   function automatic int jit(input int j);
      return int'($urandom_range(2 * j)) - j;
   endfunction

   function automatic quad_req_type quad(input int x0, input int y0, input int x1, input int y1,
                                         input int x2, input int y2, input int x3, input int y3,
                                         input int tx, input int ty, input int ta);
      quad_req_type q;
      q.x0 = coord(x0);
      q.y0 = coord(y0);
      q.x1 = coord(x1);
      q.y1 = coord(y1);
      q.x2 = coord(x2);
      q.y2 = coord(y2);
      q.x3 = coord(x3);
      q.y3 = coord(y3);
      q.len_x = 12'(tx);
      q.len_y = 12'(ty);
      q.area  = 24'(ta);
      return q;
   endfunction

   function automatic quad_req_type rectangle(input int x0, input int y0, input int w,
                                              input int h, input int tx, input int ty,
                                              input int ta);
      return quad(x0, y0, x0 + w, y0, x0 + w, y0 + h, x0, y0 + h, tx, ty, ta);
   endfunction

   // mostly axis-aligned rectangles near their targets, some pure noise
   function automatic quad_req_type candidate();
      quad_req_type q;
      int wpx, hpx, left, right, x0, y0, j, tx, ty, ta;
      if ($urandom_range(99) < 25) begin
         q.x0 = 16'($urandom);
         q.y0 = 16'($urandom);
         q.x1 = 16'($urandom);
         q.y1 = 16'($urandom);
         q.x2 = 16'($urandom);
         q.y2 = 16'($urandom);
         q.x3 = 16'($urandom);
         q.y3 = 16'($urandom);
         q.len_x = 12'($urandom);
         q.len_y = 12'($urandom);
         q.area  = 24'($urandom);
         return q;
      end
      wpx = $urandom_range(9) == 0 ? $urandom_range(2000) : $urandom_range(200);
      hpx = $urandom_range(9) == 0 ? $urandom_range(2000) : $urandom_range(200);
      x0 = int'($urandom_range(65535 - wpx * 16)) - 32768;
      y0 = int'($urandom_range(65535 - hpx * 16)) - 32768;
      case ($urandom_range(3))
         0: j = 0;
         1: j = 3;
         2: j = 40;
         default: j = 400;
      endcase
      tx = wpx;
      ty = hpx;
      ta = wpx * hpx;
      if ($urandom_range(9) < 3) begin
         tx += jit(15);
         ty += jit(15);
         ta += jit(2000);
      end
      tx = tx < 0 ? 0 : tx;
      ty = ty < 0 ? 0 : ty;
      ta = ta < 0 ? 0 : ta;
      // mirrored corners give the opposite winding
      left  = $urandom_range(1) ? x0 : x0 + wpx * 16;
      right = left == x0 ? x0 + wpx * 16 : x0;
      return quad(left + jit(j), y0 + jit(j), right + jit(j), y0 + jit(j),
                  right + jit(j), y0 + hpx * 16 + jit(j), left + jit(j),
                  y0 + hpx * 16 + jit(j), tx, ty, ta);
   endfunction

   task automatic offer(input quad_req_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_item  <= q;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_items(input int count, input int sender_pct, input int receiver_pct,
                               input int hold_at);
      send_idle_pct <= sender_pct;
      rsp_stall_pct <= receiver_pct;
      for (int i = 0; i < count; i++) begin
         if (i == hold_at) hold_requests <= hold_requests + 1;
         offer(candidate());
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct <= 24;
      rsp_stall_pct <= 83;
      @(posedge clock);

      offer(quad(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      offer(quad(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 4095, 4095, 16777215));
      offer(quad(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0, 4095, 0));
      offer(quad(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767,
                 4095, 4095, 16777215));
      offer(quad(-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768,
                 4095, 0, 16777215));
      offer(quad(32767, 32767, -32768, 32767, -32768, -32768, 32767, -32768, 4095, 4095, 0));
      // length window edges: 10 px tolerance on a 100 px square
      offer(rectangle(0, 0, 1600, 1600, 110, 100, 10000));
      offer(rectangle(0, 0, 1600, 1600, 111, 100, 10000));
      offer(rectangle(0, 0, 1600, 1600, 100, 89, 10000));
      // area window edges: 1000 px^2 tolerance
      offer(rectangle(-1600, -1600, 1600, 1600, 100, 100, 11000));
      offer(rectangle(-1600, -1600, 1600, 1600, 100, 100, 11001));
      offer(rectangle(0, 0, 1600, 1600, 100, 100, 8999));
      // sub-unit areas, truncated on scaling
      offer(quad(0, 0, 1, 0, 1, 1, 0, 0, 0, 0, 0));
      offer(quad(0, 0, 3, 0, 3, 1, 0, 1, 0, 0, 0));
      // self-crossing quad
      offer(quad(0, 0, 1600, 1600, 1600, 0, 0, 1600, 100, 100, 0));
      settle();

      write_reg(REG_LENGTH_TOL, 32'hABCD_0000);
      write_reg(REG_AREA_TOL, 32'h5A00_0000);
      write_reg(REG_AREA_EN, 32'd1);
      random_items(430, 24, 83, 200);
      settle();

      write_reg(REG_LENGTH_TOL, 32'd65535);
      write_reg(REG_AREA_TOL, 32'h00FF_FFFF);
      write_reg(REG_AREA_EN, 32'd0);
      random_items(430, 83, 24, -1);
      settle();

      write_reg(REG_LENGTH_TOL, 32'($urandom_range(400)));
      write_reg(REG_AREA_TOL, 32'($urandom_range(5000)));
      write_reg(REG_AREA_EN, 32'($urandom_range(1)));
      random_items(440, 0, 0, 150);
      settle();

      if (mismatches == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+src
src/qsc_pkg.sv
src/qsc_csr.sv
src/qsc_eval.sv
src/quad_size_check.sv
tb/quad_size_check_checker.sv
tb/tb.sv
